// ----- hw/rtl/i2cseq_pkg.sv -----
package i2cseq_pkg;

    // Command codes carried by an input word.
    typedef enum logic [2:0] {
        CMD_PUSH       = 3'd0,
        CMD_BEGIN      = 3'd1,
        CMD_START_SENT = 3'd2,
        CMD_TX_READY   = 3'd3,
        CMD_RX_BYTE    = 3'd4,
        CMD_ARB_LOST   = 3'd5,
        CMD_TICK       = 3'd6
    } cmd_e_t;

    // Action codes carried by a result word.
    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_START_WRITE = 3'd1,
        ACT_START_READ  = 3'd2,
        ACT_TX_BYTE     = 3'd3,
        ACT_RX_DELIVER  = 3'd4,
        ACT_BUS_RECOVER = 3'd5
    } act_e_t;

    typedef struct packed {
        cmd_e_t      cmd;
        logic [6:0]  slave_addr;
        logic [4:0]  write_count;
        logic [7:0]  read_count;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        act_e_t      action;
        logic [7:0]  out_byte;
        logic [6:0]  target_addr;
        logic        issue_stop;
        logic        finished;
        logic        busy_flag;
        logic        rejected;
    } result_t;

    localparam int TIMEOUT_W = 32;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd65535;

endpackage

// ----- hw/rtl/i2cseq_tx_buf.sv -----
module i2cseq_tx_buf #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/i2cseq_ctrl.sv -----
module i2cseq_ctrl #(
    parameter int TX_DEPTH = 16,
    parameter int CW       = 5,
    parameter int AW       = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  i2cseq_pkg::item_t     item,
    input  logic [31:0]           timeout_limit,
    input  logic [7:0]            rd_data,
    output i2cseq_pkg::result_t   res,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [7:0]            wr_data,
    output logic [AW-1:0]         rd_addr
);

    import i2cseq_pkg::*;

    logic [CW-1:0] tx_fill_reg,  tx_fill_next;
    logic [CW-1:0] tx_pos_reg,   tx_pos_next;
    logic [CW-1:0] tx_total_reg, tx_total_next;
    logic [7:0]    rx_pos_reg,   rx_pos_next;
    logic [7:0]    rx_total_reg, rx_total_next;
    logic [6:0]    cur_addr_reg, cur_addr_next;
    logic          active_reg,   active_next;
    logic [31:0]   wait_ticks_reg, wait_ticks_next;

    logic          tx_full;
    logic [7:0]    rx_inc;
    logic [CW-1:0] wcount_clamped;

    assign tx_full = (tx_fill_reg == CW'(TX_DEPTH));
    assign rx_inc  = rx_pos_reg + 8'd1;
    assign wcount_clamped = (32'(item.write_count) < 32'(TX_DEPTH))
                          ? CW'(item.write_count) : CW'(TX_DEPTH);

    assign wr_addr = tx_fill_reg[AW-1:0];
    assign wr_data = item.data_byte;
    // The read port follows the position after the current word, so the next
    // transmit byte is already registered when its tx-ready event arrives.
    assign rd_addr = tx_pos_next[AW-1:0];

    always_comb begin
        tx_fill_next    = tx_fill_reg;
        tx_pos_next     = tx_pos_reg;
        tx_total_next   = tx_total_reg;
        rx_pos_next     = rx_pos_reg;
        rx_total_next   = rx_total_reg;
        cur_addr_next   = cur_addr_reg;
        active_next     = active_reg;
        wait_ticks_next = wait_ticks_reg;
        wr_en           = 1'b0;
        res             = '0;
        res.action      = ACT_NONE;

        if (step_en) begin
            unique case (item.cmd)
                CMD_PUSH: begin
                    if (active_reg || tx_full) begin
                        res.rejected = 1'b1;
                    end else begin
                        wr_en        = 1'b1;
                        tx_fill_next = tx_fill_reg + CW'(1);
                    end
                end
                CMD_BEGIN: begin
                    if (active_reg) begin
                        res.rejected = 1'b1;
                    end else begin
                        cur_addr_next   = item.slave_addr;
                        tx_total_next   = wcount_clamped;
                        rx_total_next   = item.read_count;
                        tx_pos_next     = '0;
                        rx_pos_next     = '0;
                        tx_fill_next    = '0;
                        wait_ticks_next = '0;
                        active_next     = 1'b1;
                        res.action = (wcount_clamped != '0 || item.read_count == 8'd0)
                                   ? ACT_START_WRITE : ACT_START_READ;
                    end
                end
                CMD_START_SENT: begin
                    if (active_reg && rx_total_reg == 8'd1 && tx_pos_reg == tx_total_reg) begin
                        res.issue_stop = 1'b1;
                    end
                end
                CMD_TX_READY: begin
                    if (active_reg) begin
                        if (tx_pos_reg < tx_total_reg) begin
                            res.action   = ACT_TX_BYTE;
                            res.out_byte = rd_data;
                            tx_pos_next  = tx_pos_reg + CW'(1);
                        end else if (rx_total_reg != 8'd0) begin
                            res.action  = ACT_START_READ;
                            rx_pos_next = '0;
                        end else begin
                            res.issue_stop = 1'b1;
                            res.finished   = 1'b1;
                            active_next    = 1'b0;
                            tx_pos_next    = '0;
                            rx_total_next  = '0;
                        end
                    end
                end
                CMD_RX_BYTE: begin
                    if (active_reg && tx_pos_reg == tx_total_reg && rx_total_reg != 8'd0) begin
                        res.action   = ACT_RX_DELIVER;
                        res.out_byte = item.data_byte;
                        rx_pos_next  = rx_inc;
                        if (rx_inc < rx_total_reg) begin
                            if (rx_inc == rx_total_reg - 8'd1) begin
                                res.issue_stop = 1'b1;
                            end
                        end else begin
                            res.finished  = 1'b1;
                            active_next   = 1'b0;
                            tx_pos_next   = '0;
                            rx_total_next = '0;
                        end
                    end
                end
                CMD_ARB_LOST: begin
                    if (active_reg) begin
                        res.issue_stop = 1'b1;
                        res.finished   = 1'b1;
                        active_next    = 1'b0;
                    end
                end
                CMD_TICK: begin
                    if (active_reg) begin
                        if (wait_ticks_reg > timeout_limit) begin
                            res.action      = ACT_BUS_RECOVER;
                            res.finished    = 1'b1;
                            active_next     = 1'b0;
                            wait_ticks_next = '0;
                        end else if (wait_ticks_reg != '1) begin
                            wait_ticks_next = wait_ticks_reg + 32'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        res.target_addr = cur_addr_next;
        res.busy_flag   = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_fill_reg    <= '0;
            tx_pos_reg     <= '0;
            tx_total_reg   <= '0;
            rx_pos_reg     <= '0;
            rx_total_reg   <= '0;
            cur_addr_reg   <= '0;
            active_reg     <= 1'b0;
            wait_ticks_reg <= '0;
        end else begin
            tx_fill_reg    <= tx_fill_next;
            tx_pos_reg     <= tx_pos_next;
            tx_total_reg   <= tx_total_next;
            rx_pos_reg     <= rx_pos_next;
            rx_total_reg   <= rx_total_next;
            cur_addr_reg   <= cur_addr_next;
            active_reg     <= active_next;
            wait_ticks_reg <= wait_ticks_next;
        end
    end

endmodule

// ----- hw/rtl/i2c_master_transaction_sequencer_unit.sv -----
// I2C master write-then-read transaction sequencer. Each input word is either
// a transmit byte push, a begin request (slave address, write count, read
// count) or an event from the bus controller (start sent, transmit ready,
// byte received, arbitration lost, timer tick), and each word produces exactly
// one result word telling the controller what to do next: start in write or
// read mode, transmit a byte, deliver a received byte, request a stop, or
// force bus recovery after the tick timeout. Throughput is one word per clock
// cycle while the result side keeps taking results; an accepted word waits in
// the input register, and its result is written to the result register and
// stays there until it is taken. The decision logic and the transmit buffer's
// registered read port sit between the two registers.
// The input side keeps accepting while a result waits to be taken, as long as
// the input register is empty or moving forward. The timeout limit register
// resets to 65535 and should be written only while the sequencer is idle.
// Transmit buffer contents are undefined after reset until bytes are pushed.
module i2c_master_transaction_sequencer_unit #(
    parameter int TX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [6:0]  s_slave_addr,
    input  logic [4:0]  s_write_count,
    input  logic [7:0]  s_read_count,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [7:0]  m_out_byte,
    output logic [6:0]  m_target_addr,
    output logic        m_issue_stop,
    output logic        m_finished,
    output logic        m_busy_flag,
    output logic        m_rejected
);

    import i2cseq_pkg::*;

    // Counter width holds the depth itself; the address width indexes entries.
    localparam int CW = $clog2(TX_DEPTH + 1);
    localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    logic [TIMEOUT_W-1:0] timeout_limit_reg;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    logic    step;
    result_t step_res;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // A word in the input register is processed when the result register is
    // free or being emptied in the same cycle.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_limit_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.cmd         <= cmd_e_t'(s_cmd);
            in_item_reg.slave_addr  <= s_slave_addr;
            in_item_reg.write_count <= s_write_count;
            in_item_reg.read_count  <= s_read_count;
            in_item_reg.data_byte   <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= step_res;
        end
    end

    i2cseq_ctrl #(
        .TX_DEPTH (TX_DEPTH),
        .CW       (CW),
        .AW       (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step),
        .item          (in_item_reg),
        .timeout_limit (timeout_limit_reg),
        .rd_data       (rd_data),
        .res           (step_res),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr)
    );

    i2cseq_tx_buf #(
        .DEPTH (TX_DEPTH),
        .AW    (AW)
    ) u_tx_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid       = out_valid_reg;
    assign m_action      = out_res_reg.action;
    assign m_out_byte    = out_res_reg.out_byte;
    assign m_target_addr = out_res_reg.target_addr;
    assign m_issue_stop  = out_res_reg.issue_stop;
    assign m_finished    = out_res_reg.finished;
    assign m_busy_flag   = out_res_reg.busy_flag;
    assign m_rejected    = out_res_reg.rejected;

endmodule
